### rtl/core/pair_penalty_weight_table_defines.svh
// Assertion macros shared by the pair penalty weight table RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef PAIR_PENALTY_WEIGHT_TABLE_DEFINES_SVH
`define PAIR_PENALTY_WEIGHT_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every rising clock edge, skipped while reset is high.
`define PPWT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define PPWT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PPWT_ASSERT(lbl, prop, msg)
`define PPWT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/ppwt_pkg.sv
// Types and fixed-point constants of the pair penalty weight table.
// Used by pair_penalty_weight_table; depends on nothing else.
`default_nettype none

package ppwt_pkg;

   // Field widths of the stream payloads.
   localparam int ACTION_W  = 2;
   localparam int ITEM_W    = 5;
   localparam int WEIGHT_W  = 23;
   localparam int BIAS_W    = 18;
   localparam int GAIN_W    = 17;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 48;

   // Q16 constants, each rounded to the nearest 1/65536; DIV_LIMIT is a plain integer stall streak.
   localparam logic [WEIGHT_W-1:0] ONE_Q16    = 23'd65536;
   localparam logic [WEIGHT_W-1:0] COL_CAP    = 23'd4194304;
   localparam logic [GAIN_W-1:0]   COL_GAIN   = 17'd73400;
   localparam logic [15:0]         COL_ADD    = 16'd13107;
   localparam logic [11:0]         COL_STEP   = 12'd2621;
   localparam logic [GAIN_W-1:0]   RES_DECAY  = 17'd64553;
   localparam logic [WEIGHT_W-1:0] STALL_CAP  = 23'd6291456;
   localparam logic [15:0]         STALL_ADD  = 16'd22938;
   localparam logic [12:0]         STALL_STEP = 13'd6554;
   localparam logic [BIAS_W-1:0]   BIAS_CAP   = 18'd131072;
   localparam logic [1:0]          DIV_LIMIT  = 2'd2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_COLLIDE = 2'd0,
      ACT_RESOLVE = 2'd1,
      ACT_STALL   = 2'd2,
      ACT_QUERY   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_WB
   } state_type;

endpackage

`default_nettype wire

### rtl/core/pair_penalty_weight_table.sv
// Pair penalty weight table: one synchronous memory holding weight and streaks
// per unordered item pair, updated by read-modify-write. Depends on ppwt_pkg and
// pair_penalty_weight_table_defines.svh.
//
// Usage. The req_ stream carries one event per transaction: an action and two
// item indices. The pair is looked up by its smaller and larger index (indices
// wrap modulo ITEMS). Collision, resolved and stalled actions update the pair;
// query leaves it untouched. Every request produces exactly one rsp_
// transaction with the pair's weight, bias and diversify flag after the update.
//
// Sequence. A request is accepted when the block is idle, and the memory is read
// at that same edge; a multiply stage and a write-back stage follow, the response
// is registered at write-back, and a new request can be taken in the cycle after
// write-back. The block takes no new request while one is in flight; this is set
// by the read-modify-write loop through the single-port state memory.
//
// Reset. After reset the block sweeps the whole memory, writing weight 1.0 and
// zero streaks one entry per cycle, with req_tready low throughout.
//
// Stall. The response sits in an output register. A new request is accepted
// while it waits; the write-back of that request holds until rsp_tready frees
// the register, so no transaction is lost or repeated.
`default_nettype none
`include "pair_penalty_weight_table_defines.svh"

module pair_penalty_weight_table #(
   parameter int ITEMS       = 32,
   parameter int STREAK_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request stream.
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: action [1:0], item_a [6:2], item_b [11:7], zero [15:12]
   input  wire logic [ppwt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // Response stream.
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // tdata: pair_weight [22:0], bias [40:23], diversify [41], zero [47:42]
   output logic [ppwt_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);

   // Table geometry.
   localparam int DEPTH   = ITEMS * ITEMS;
   localparam int IDX_W   = (ITEMS > 1) ? $clog2(ITEMS) : 1;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int SB      = STREAK_BITS;
   localparam int WORD_W  = ppwt_pkg::WEIGHT_W + 2 * SB;
   localparam int LUT_N   = 2 ** ppwt_pkg::ITEM_W;

   // Arithmetic widths.
   localparam int WPROD_W = ppwt_pkg::WEIGHT_W + ppwt_pkg::GAIN_W;
   localparam int WSC_W   = WPROD_W - 16;
   localparam int CP_W    = SB + 12;
   localparam int SP_W    = SB + 13;
   localparam int BP_W    = SB + 14;
   localparam int SUM_W   = ((SP_W > WSC_W) ? SP_W : WSC_W) + 2;

   // Smallest bias a diversifying pair can show (stall streak of two).
   localparam logic [ppwt_pkg::BIAS_W-1:0] DIV_BIAS_MIN = 18'd91750;

   // ------------------------------------------------------------------
   // Index folding: a constant table maps each 5-bit index to index mod ITEMS.
   // ------------------------------------------------------------------
   logic [IDX_W-1:0] idx_lut [LUT_N];

   for (genvar g = 0; g < LUT_N; g++) begin : g_lut
      assign idx_lut[g] = IDX_W'(g % ITEMS);
   end

   logic [ppwt_pkg::ACTION_W-1:0] req_action;
   logic [ppwt_pkg::ITEM_W-1:0]   req_item_a;
   logic [ppwt_pkg::ITEM_W-1:0]   req_item_b;
   logic [IDX_W-1:0]              idx_a;
   logic [IDX_W-1:0]              idx_b;
   logic [IDX_W-1:0]              idx_lo;
   logic [IDX_W-1:0]              idx_hi;
   logic [ADDR_W-1:0]             req_addr;

   assign req_action = req_tdata[1:0];
   assign req_item_a = req_tdata[6:2];
   assign req_item_b = req_tdata[11:7];
   assign idx_a      = idx_lut[req_item_a];
   assign idx_b      = idx_lut[req_item_b];
   assign idx_lo     = (idx_a < idx_b) ? idx_a : idx_b;
   assign idx_hi     = (idx_a < idx_b) ? idx_b : idx_a;
   assign req_addr   = ADDR_W'(ADDR_W'(idx_lo) * ADDR_W'(ITEMS) + ADDR_W'(idx_hi));

   // ------------------------------------------------------------------
   // Control state.
   // ------------------------------------------------------------------
   ppwt_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                req_accept;
   logic                clr_done;
   logic                wb_go;
   logic                rd_en;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [WORD_W-1:0]   wr_word;

   assign req_accept = req_tvalid && req_tready;
   assign clr_done   = (clr_cnt_ff == ADDR_W'(DEPTH - 1));
   assign wb_go      = (state_ff == ppwt_pkg::ST_WB) && (!rsp_valid_ff || rsp_tready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppwt_pkg::ST_CLEAR: begin
            if (clr_done) state_in = ppwt_pkg::ST_IDLE;
         end
         ppwt_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ppwt_pkg::ST_MUL;
         end
         ppwt_pkg::ST_MUL: begin
            state_in = ppwt_pkg::ST_WB;
         end
         ppwt_pkg::ST_WB: begin
            if (wb_go) state_in = ppwt_pkg::ST_IDLE;
         end
         default: begin
            state_in = ppwt_pkg::ST_CLEAR;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Payload registers of the item in flight.
   // ------------------------------------------------------------------
   ppwt_pkg::action_type act_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [WORD_W-1:0]    rd_word_ff;

   // Stage one results.
   logic [WSC_W-1:0]     wsc_ff, wsc_in;
   logic [SB-1:0]        col_new_ff, col_new_in;
   logic [SB-1:0]        stall_new_ff, stall_new_in;
   logic [CP_W-1:0]      col_prod_ff, col_prod_in;
   logic [SP_W-1:0]      stall_prod_ff, stall_prod_in;

   // Outputs.
   logic [ppwt_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [ppwt_pkg::WEIGHT_W-1:0] rd_weight;
   logic [SB-1:0]                 rd_col;
   logic [SB-1:0]                 rd_stall;
   logic [SB-1:0]                 col_inc;
   logic [SB-1:0]                 stall_inc;
   logic [ppwt_pkg::GAIN_W-1:0]   gain;
   logic [WPROD_W-1:0]            wprod;

   assign rd_weight = rd_word_ff[WORD_W-1 -: ppwt_pkg::WEIGHT_W];
   assign rd_col    = rd_word_ff[2*SB-1 -: SB];
   assign rd_stall  = rd_word_ff[SB-1:0];
   assign col_inc   = (rd_col == {SB{1'b1}}) ? rd_col : rd_col + SB'(1);
   assign stall_inc = (rd_stall == {SB{1'b1}}) ? rd_stall : rd_stall + SB'(1);
   assign gain      = (act_ff == ppwt_pkg::ACT_COLLIDE) ? ppwt_pkg::COL_GAIN
                                                        : ppwt_pkg::RES_DECAY;
   assign wprod     = WPROD_W'(rd_weight) * WPROD_W'(gain);

   // Stage one: streak updates and the products.
   always_comb begin
      wsc_in       = WSC_W'(rd_weight);
      col_new_in   = rd_col;
      stall_new_in = rd_stall;
      case (act_ff)
         ppwt_pkg::ACT_COLLIDE: begin
            wsc_in     = wprod[WPROD_W-1:16];
            col_new_in = col_inc;
         end
         ppwt_pkg::ACT_RESOLVE: begin
            wsc_in       = wprod[WPROD_W-1:16];
            col_new_in   = '0;
            stall_new_in = '0;
         end
         ppwt_pkg::ACT_STALL: begin
            stall_new_in = stall_inc;
         end
         default: begin
         end
      endcase
      col_prod_in   = CP_W'(col_new_in) * CP_W'(ppwt_pkg::COL_STEP);
      stall_prod_in = SP_W'(stall_new_in) * SP_W'(ppwt_pkg::STALL_STEP);
   end

   // Stage two: sums, clamps and the bias.
   logic [SUM_W-1:0]              sum_col;
   logic [SUM_W-1:0]              sum_stall;
   logic [ppwt_pkg::WEIGHT_W-1:0] w_new;
   logic [BP_W-1:0]               bias_prod;
   logic [BP_W-1:0]               bias_clamped;
   logic [ppwt_pkg::BIAS_W-1:0]   bias;
   logic                          diversify;

   assign sum_col   = SUM_W'(wsc_ff) + SUM_W'(ppwt_pkg::COL_ADD) + SUM_W'(col_prod_ff);
   assign sum_stall = SUM_W'(wsc_ff) + SUM_W'(ppwt_pkg::STALL_ADD) + SUM_W'(stall_prod_ff);

   always_comb begin
      case (act_ff)
         ppwt_pkg::ACT_COLLIDE: begin
            w_new = (sum_col > SUM_W'(ppwt_pkg::COL_CAP))
                  ? ppwt_pkg::COL_CAP : sum_col[ppwt_pkg::WEIGHT_W-1:0];
         end
         ppwt_pkg::ACT_RESOLVE: begin
            w_new = (wsc_ff < WSC_W'(ppwt_pkg::ONE_Q16))
                  ? ppwt_pkg::ONE_Q16 : wsc_ff[ppwt_pkg::WEIGHT_W-1:0];
         end
         ppwt_pkg::ACT_STALL: begin
            w_new = (sum_stall > SUM_W'(ppwt_pkg::STALL_CAP))
                  ? ppwt_pkg::STALL_CAP : sum_stall[ppwt_pkg::WEIGHT_W-1:0];
         end
         default: begin
            w_new = wsc_ff[ppwt_pkg::WEIGHT_W-1:0];
         end
      endcase
   end

   // 13107 * s equals 2 * (6554 * s) - s, which reuses the stall product.
   assign bias_prod    = {stall_prod_ff, 1'b0} - BP_W'(stall_new_ff);
   assign bias_clamped = (bias_prod > BP_W'(ppwt_pkg::BIAS_CAP))
                       ? BP_W'(ppwt_pkg::BIAS_CAP) : bias_prod;
   assign bias         = bias_clamped[ppwt_pkg::BIAS_W-1:0]
                       + ppwt_pkg::BIAS_W'(ppwt_pkg::ONE_Q16);
   assign diversify    = (stall_new_ff >= SB'(ppwt_pkg::DIV_LIMIT));

   // Outputs of the controller.
   always_comb begin
      req_tready   = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_word      = {w_new, col_new_ff, stall_new_ff};
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ppwt_pkg::ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_word    = {ppwt_pkg::ONE_Q16, {(2 * SB){1'b0}}};
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         end
         ppwt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            rd_en      = req_tvalid;
         end
         ppwt_pkg::ST_WB: begin
            if (wb_go) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, diversify, bias, w_new};
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // State memory: weight, collision streak and stall streak per pair.
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[req_addr];
      end
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppwt_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff  <= ppwt_pkg::action_type'(req_action);
         addr_ff <= req_addr;
      end
      if (state_ff == ppwt_pkg::ST_MUL) begin
         wsc_ff        <= wsc_in;
         col_new_ff    <= col_new_in;
         stall_new_ff  <= stall_new_in;
         col_prod_ff   <= col_prod_in;
         stall_prod_ff <= stall_prod_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `PPWT_ASSERT(a_accept_starts_work,
      req_accept |=> (state_ff == ppwt_pkg::ST_MUL),
      "accepted request did not enter the multiply stage")

   `PPWT_ASSERT(a_weight_in_range,
      (state_ff == ppwt_pkg::ST_WB) && wb_go |->
         (w_new >= ppwt_pkg::ONE_Q16) && (w_new <= ppwt_pkg::STALL_CAP),
      "written weight outside 1.0 to 96.0")

   `PPWT_ASSERT(a_wb_holds,
      (state_ff == ppwt_pkg::ST_WB) && !wb_go |=>
         (state_ff == ppwt_pkg::ST_WB) && $stable(addr_ff) && $stable(wsc_ff),
      "stalled write-back lost its item")

   `PPWT_ASSERT(a_bias_matches_flag,
      rsp_valid_ff |-> (rsp_data_ff[41] == (rsp_data_ff[40:23] >= DIV_BIAS_MIN)),
      "diversify flag disagrees with bias")

   `PPWT_ASSERT_ALWAYS(a_no_accept_in_clear,
      (state_ff == ppwt_pkg::ST_CLEAR) |-> !req_accept,
      "request accepted during the clearing sweep")

endmodule

`default_nettype wire
